/* rtl/video_register_interface_core_macros.svh */
// Assertion macros shared by the video register interface RTL.
`ifndef VIDEO_REGISTER_INTERFACE_CORE_MACROS_SVH
`define VIDEO_REGISTER_INTERFACE_CORE_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, held off during reset
`define VRIF_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, held off during reset
`define VRIF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`else

`define VRIF_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define VRIF_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* rtl/vrif_pkg.sv */
// Types and constants of the video register interface.
`timescale 1ns / 1ps

package vrif_pkg;

    // Bus access and frame event codes
    typedef enum logic [3:0] {
        MODE_CTRL_WR    = 4'd0,
        MODE_MASK_WR    = 4'd1,
        MODE_STATUS_RD  = 4'd2,
        MODE_SPR_ADDR   = 4'd3,
        MODE_SPR_WR     = 4'd4,
        MODE_SPR_RD     = 4'd5,
        MODE_SCROLL_WR  = 4'd6,
        MODE_ADDR_WR    = 4'd7,
        MODE_DATA_WR    = 4'd8,
        MODE_DATA_RD    = 4'd9,
        MODE_VBL_START  = 4'd10,
        MODE_VBL_MISS   = 4'd11,
        MODE_PRE_CLEAR  = 4'd12
    } mode_t;

    // Sequencer states
    typedef enum logic {
        ST_IDLE   = 1'b0,
        ST_LOOKUP = 1'b1
    } fsm_t;

    localparam int unsigned VADDR_W = 15;

    // Sprite memory size; the 8-bit sprite address covers it exactly
    localparam int unsigned SPRITE_MEM_BYTES = 256;

    localparam logic [7:0]         ATTR_MASK    = 8'he3;
    localparam logic [7:0]         PAL_MASK     = 8'h30;
    localparam logic [7:0]         STATUS_PRE   = 8'h1f;
    localparam logic [VADDR_W-1:0] PAL_BASE     = 15'h3f00;
    localparam logic [VADDR_W-1:0] PAL_END      = 15'h4000;
    localparam logic [VADDR_W-1:0] INC_ACROSS   = 15'd32;
    localparam logic [VADDR_W-1:0] INC_DOWN     = 15'd1;
    localparam logic [1:0]         ATTR_BYTE    = 2'd2;

    // One input transfer
    typedef struct packed {
        mode_t      mode;
        logic [7:0] value;
        logic [7:0] mem_byte;
        logic [7:0] mem_byte_below;
        logic       ignore_writes;
    } item_t;

    // One result; sprite reads are finished after the memory returns data
    typedef struct packed {
        logic [7:0]         read_data;
        logic               mem_write;
        logic [VADDR_W-1:0] mem_address;
        logic [7:0]         mem_write_data;
        logic               nmi_rise;
        logic               spr_read;
        logic               spr_attr;
    } result_t;

    // Sprite memory port request
    typedef struct packed {
        logic       wr_en;
        logic       rd_en;
        logic [7:0] addr;
        logic [7:0] wdata;
    } spr_req_t;

endpackage

/* rtl/vrif_sprite_mem.sv */
// Sprite attribute memory: synchronous RAM with per-entry valid bits.
`timescale 1ns / 1ps

`include "video_register_interface_core_macros.svh"

module vrif_sprite_mem #(
    parameter int unsigned DEPTH = 256
) (
    input  logic              clk,
    input  logic              rst_n,
    input  vrif_pkg::spr_req_t req,
    output logic [7:0]        rd_data
);

    localparam int unsigned AW = $clog2(DEPTH);

    logic [7:0]       mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [7:0]       rd_raw_reg;
    logic             rd_valid_reg;
    logic [AW-1:0]    idx;

    assign idx = req.addr[AW-1:0];

    // RAM write and registered read
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[idx] <= req.wdata;
        end
        if (req.rd_en)
        begin
            rd_raw_reg <= mem[idx];
        end
    end

    // Valid bits: unwritten entries read as zero after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
            begin
                valid_reg[idx] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_valid_reg <= valid_reg[idx];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_raw_reg : 8'h00;

    `VRIF_ASSERT_NEXT(a_wr_marks_valid, clk, rst_n, req.wr_en, valid_reg[$past(idx)])

endmodule

/* rtl/vrif_regs.sv */
// Register file: control, status, scroll addresses and result formation.
`timescale 1ns / 1ps

`include "video_register_interface_core_macros.svh"

module vrif_regs (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  vrif_pkg::item_t    item,
    output vrif_pkg::spr_req_t spr_req,
    output vrif_pkg::result_t  result
);

    logic [7:0]                    control_reg, control_next;
    logic [7:0]                    mask_reg, mask_next;
    logic [7:0]                    status_reg, status_next;
    logic                          toggle_reg, toggle_next;
    logic [vrif_pkg::VADDR_W-1:0]  current_reg, current_next;
    logic [vrif_pkg::VADDR_W-1:0]  temp_reg, temp_next;
    logic [2:0]                    fine_x_reg, fine_x_next;
    logic [7:0]                    rbuf_reg, rbuf_next;
    logic [7:0]                    spr_addr_reg, spr_addr_next;
    logic                          vbl_miss_reg, vbl_miss_next;
    logic                          nmi_level_reg, nmi_level_next;
    logic [vrif_pkg::VADDR_W-1:0]  current_inc;
    logic                          in_palette;
    logic [7:0]                    rd;

    assign current_inc = current_reg +
        (control_reg[2] ? vrif_pkg::INC_ACROSS : vrif_pkg::INC_DOWN);
    assign in_palette = (current_reg >= vrif_pkg::PAL_BASE) &&
                        (current_reg < vrif_pkg::PAL_END);

    // Next state of every register for the item at hand
    always_comb
    begin
        control_next  = control_reg;
        mask_next     = mask_reg;
        status_next   = status_reg;
        toggle_next   = toggle_reg;
        current_next  = current_reg;
        temp_next     = temp_reg;
        fine_x_next   = fine_x_reg;
        rbuf_next     = rbuf_reg;
        spr_addr_next = spr_addr_reg;
        vbl_miss_next = vbl_miss_reg;
        rd            = 8'h00;
        unique case (item.mode)
            vrif_pkg::MODE_CTRL_WR:
            begin
                if (!item.ignore_writes)
                begin
                    control_next      = item.value;
                    temp_next[11:10]  = item.value[1:0];
                end
            end
            vrif_pkg::MODE_MASK_WR:
            begin
                if (!item.ignore_writes)
                begin
                    mask_next = item.value;
                end
            end
            vrif_pkg::MODE_STATUS_RD:
            begin
                toggle_next    = 1'b0;
                rd             = status_reg;
                status_next[7] = 1'b0;
                if (vbl_miss_reg)
                begin
                    rd[7] = 1'b0;
                end
            end
            vrif_pkg::MODE_SPR_ADDR:
            begin
                spr_addr_next = item.value;
            end
            vrif_pkg::MODE_SPR_WR:
            begin
                spr_addr_next = spr_addr_reg + 8'd1;
            end
            vrif_pkg::MODE_SPR_RD:
            begin
                rd = 8'h00;
            end
            vrif_pkg::MODE_SCROLL_WR:
            begin
                if (!item.ignore_writes)
                begin
                    if (!toggle_reg)
                    begin
                        fine_x_next    = item.value[2:0];
                        temp_next[4:0] = item.value[7:3];
                    end
                    else
                    begin
                        temp_next[14:12] = item.value[2:0];
                        temp_next[9:5]   = item.value[7:3];
                    end
                    toggle_next = ~toggle_reg;
                end
            end
            vrif_pkg::MODE_ADDR_WR:
            begin
                if (!item.ignore_writes)
                begin
                    if (!toggle_reg)
                    begin
                        temp_next = {1'b0, item.value[5:0], temp_reg[7:0]};
                    end
                    else
                    begin
                        temp_next    = {temp_reg[14:8], item.value};
                        current_next = {temp_reg[14:8], item.value};
                    end
                    toggle_next = ~toggle_reg;
                end
            end
            vrif_pkg::MODE_DATA_WR:
            begin
                current_next = current_inc;
            end
            vrif_pkg::MODE_DATA_RD:
            begin
                if (in_palette)
                begin
                    rbuf_next = item.mem_byte_below;
                    rd        = mask_reg[0] ? (item.mem_byte & vrif_pkg::PAL_MASK)
                                            : item.mem_byte;
                end
                else
                begin
                    rbuf_next = item.mem_byte;
                    rd        = rbuf_reg;
                end
                current_next = current_inc;
            end
            vrif_pkg::MODE_VBL_START:
            begin
                vbl_miss_next  = 1'b1;
                status_next[7] = 1'b1;
            end
            vrif_pkg::MODE_VBL_MISS:
            begin
                vbl_miss_next = 1'b0;
            end
            vrif_pkg::MODE_PRE_CLEAR:
            begin
                status_next = status_reg & vrif_pkg::STATUS_PRE;
            end
            default:
            begin
                rd = 8'h00;
            end
        endcase
        nmi_level_next = control_next[7] & status_next[7];
    end

    // Result fields; sprite reads get their byte from the memory in the next cycle
    always_comb
    begin
        result.read_data      = rd;
        result.mem_write      = (item.mode == vrif_pkg::MODE_DATA_WR);
        result.mem_address    = result.mem_write ? current_reg : current_next;
        result.mem_write_data = result.mem_write ? item.value : 8'h00;
        result.nmi_rise       = nmi_level_next & ~nmi_level_reg;
        result.spr_read       = (item.mode == vrif_pkg::MODE_SPR_RD);
        result.spr_attr       = (spr_addr_reg[1:0] == vrif_pkg::ATTR_BYTE);
    end

    // Sprite memory request
    always_comb
    begin
        spr_req.wr_en = accept && (item.mode == vrif_pkg::MODE_SPR_WR);
        spr_req.rd_en = accept && (item.mode == vrif_pkg::MODE_SPR_RD);
        spr_req.addr  = spr_addr_reg;
        spr_req.wdata = item.value;
    end

    // State update on each accepted transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            control_reg   <= '0;
            mask_reg      <= '0;
            status_reg    <= '0;
            toggle_reg    <= 1'b0;
            current_reg   <= '0;
            temp_reg      <= '0;
            fine_x_reg    <= '0;
            rbuf_reg      <= '0;
            spr_addr_reg  <= '0;
            vbl_miss_reg  <= 1'b0;
            nmi_level_reg <= 1'b0;
        end
        else if (accept)
        begin
            control_reg   <= control_next;
            mask_reg      <= mask_next;
            status_reg    <= status_next;
            toggle_reg    <= toggle_next;
            current_reg   <= current_next;
            temp_reg      <= temp_next;
            fine_x_reg    <= fine_x_next;
            rbuf_reg      <= rbuf_next;
            spr_addr_reg  <= spr_addr_next;
            vbl_miss_reg  <= vbl_miss_next;
            nmi_level_reg <= nmi_level_next;
        end
    end

    `VRIF_ASSERT_NEXT(a_addr_holds_idle, clk, rst_n, !accept, $stable(current_reg))
    `VRIF_ASSERT_IMPLY(a_nmi_needs_both, clk, rst_n, accept && result.nmi_rise, control_next[7] && status_next[7] && !nmi_level_reg)

endmodule

/* rtl/video_register_interface_core.sv */
// Top level of the video register interface: sequencer and output register.
`timescale 1ns / 1ps

// Each transfer on the slave side is one CPU register access or one frame
// timing event and produces exactly one result transfer on the master side.
// An item passes through IDLE and LOOKUP: the accept cycle in IDLE updates
// all registers and issues the sprite memory read; LOOKUP merges the
// registered memory byte into the result and loads the output register,
// waiting while the output register holds an unaccepted result. No new
// item is taken until LOOKUP has loaded the output register. A finished
// result may wait there while the next item is accepted. The sprite memory
// reads as zero after reset through per-entry valid bits; no clearing pass.
`include "video_register_interface_core_macros.svh"

module video_register_interface_core (
    input  logic        clk,
    input  logic        rst_n,
    // tdata: value[7:0], mem_byte[15:8], mem_byte_below[23:16],
    //        ignore_writes[24], zero[31:25]
    input  logic [31:0] s_tdata,
    // tuser: mode[3:0]
    input  logic [3:0]  s_tuser,
    input  logic        s_tvalid,
    output logic        s_tready,
    // tdata: read_data[7:0], mem_write[8], mem_address[23:9],
    //        mem_write_data[31:24], nmi_rise[32], zero[39:33]
    output logic [39:0] m_tdata,
    output logic        m_tvalid,
    input  logic        m_tready
);

    vrif_pkg::fsm_t     state_reg, state_next;
    vrif_pkg::item_t    item;
    vrif_pkg::spr_req_t spr_req;
    vrif_pkg::result_t  result;
    vrif_pkg::result_t  pend_reg;
    logic [7:0]         spr_rd_data;
    logic [7:0]         spr_byte;
    logic               accept;
    logic               out_load;
    logic               m_tvalid_reg;
    logic [39:0]        m_tdata_reg;

    // Unpack the incoming transfer
    always_comb
    begin
        item.mode           = vrif_pkg::mode_t'(s_tuser);
        item.value          = s_tdata[7:0];
        item.mem_byte       = s_tdata[15:8];
        item.mem_byte_below = s_tdata[23:16];
        item.ignore_writes  = s_tdata[24];
    end

    assign accept = s_tvalid && s_tready;

    vrif_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .item    (item),
        .spr_req (spr_req),
        .result  (result)
    );

    vrif_sprite_mem #(
        .DEPTH (vrif_pkg::SPRITE_MEM_BYTES)
    ) u_sprite_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (spr_req),
        .rd_data (spr_rd_data)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            vrif_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = vrif_pkg::ST_LOOKUP;
                end
            end
            vrif_pkg::ST_LOOKUP:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    state_next = vrif_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = vrif_pkg::ST_IDLE;
            end
        endcase
    end

    // State outputs
    always_comb
    begin
        s_tready = 1'b0;
        out_load = 1'b0;
        unique case (state_reg)
            vrif_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
            end
            vrif_pkg::ST_LOOKUP:
            begin
                out_load = !m_tvalid_reg || m_tready;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    // Sprite byte with attribute masking
    assign spr_byte = spr_rd_data & (pend_reg.spr_attr ? vrif_pkg::ATTR_MASK : 8'hff);

    // Pending result captured at accept
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pend_reg <= result;
        end
        if (out_load)
        begin
            m_tdata_reg <= {7'd0, pend_reg.nmi_rise, pend_reg.mem_write_data,
                            pend_reg.mem_address, pend_reg.mem_write,
                            pend_reg.spr_read ? spr_byte : pend_reg.read_data};
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= vrif_pkg::ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `VRIF_ASSERT_NEXT(a_accept_to_lookup, clk, rst_n, accept, state_reg == vrif_pkg::ST_LOOKUP)
    `VRIF_ASSERT_NEXT(a_load_gives_valid, clk, rst_n, out_load, m_tvalid_reg)

endmodule

/* dv/vrif_checker.sv */
// Checker for the video register interface: predicts each result and compares it.
`timescale 1ns / 1ps

module vrif_checker
    import vrif_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [31:0] s_tdata,
    input  logic [3:0]  s_tuser,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] m_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    output int          errors,
    output int          pending
);

    // One predicted bus result
    typedef struct packed {
        logic [7:0]         read_data;
        logic               mem_write;
        logic [VADDR_W-1:0] mem_address;
        logic [7:0]         mem_write_data;
        logic               nmi_rise;
    } bus_result_t;

    // Shadow copy of the register file
    logic [7:0]         ctrl_q;
    logic [7:0]         mask_q;
    logic [7:0]         status_q;
    logic               toggle_q;
    logic [VADDR_W-1:0] vaddr_q;
    logic [VADDR_W-1:0] taddr_q;
    logic [2:0]         finex_q;
    logic [7:0]         rbuf_q;
    logic [7:0]         spr_addr_q;
    logic [7:0]         spr_mem [256];
    logic               vbl_miss_q;
    logic               nmi_q;

    bus_result_t expected_results [$];
    int          err_cnt = 0;

    assign errors = err_cnt;

    // Apply one access to the shadow registers and work out its result
    task automatic apply_access(input logic [3:0] md, input logic [7:0] v,
                                input logic [7:0] mb, input logic [7:0] mbb,
                                input logic ign, output bus_result_t r);
        logic lvl;
        r = '0;
        case (md)
            MODE_CTRL_WR:
                if (!ign)
                begin
                    ctrl_q = v;
                    taddr_q[11:10] = v[1:0];
                end
            MODE_MASK_WR:
                if (!ign)
                    mask_q = v;
            MODE_STATUS_RD:
            begin
                toggle_q = 1'b0;
                r.read_data = status_q;
                status_q[7] = 1'b0;
                // vblank flag hidden while the miss window is open
                if (vbl_miss_q)
                    r.read_data[7] = 1'b0;
            end
            MODE_SPR_ADDR:
                spr_addr_q = v;
            MODE_SPR_WR:
            begin
                spr_mem[spr_addr_q] = v;
                spr_addr_q = spr_addr_q + 8'd1;
            end
            MODE_SPR_RD:
                r.read_data = spr_mem[spr_addr_q] &
                              ((spr_addr_q[1:0] == ATTR_BYTE) ? ATTR_MASK : 8'hff);
            MODE_SCROLL_WR:
                if (!ign)
                begin
                    if (!toggle_q)
                    begin
                        finex_q = v[2:0];
                        taddr_q[4:0] = v[7:3];
                    end
                    else
                    begin
                        taddr_q[14:12] = v[2:0];
                        taddr_q[9:5] = v[7:3];
                    end
                    toggle_q = ~toggle_q;
                end
            MODE_ADDR_WR:
                if (!ign)
                begin
                    if (!toggle_q)
                        taddr_q = {1'b0, v[5:0], taddr_q[7:0]};
                    else
                    begin
                        taddr_q[7:0] = v;
                        vaddr_q = taddr_q;
                    end
                    toggle_q = ~toggle_q;
                end
            MODE_DATA_WR:
            begin
                r.mem_write = 1'b1;
                r.mem_address = vaddr_q;
                r.mem_write_data = v;
                vaddr_q = vaddr_q + (ctrl_q[2] ? INC_ACROSS : INC_DOWN);
            end
            MODE_DATA_RD:
            begin
                r.read_data = rbuf_q;
                rbuf_q = mb;
                // palette range bypasses the read buffer
                if (vaddr_q >= PAL_BASE && vaddr_q < PAL_END)
                begin
                    rbuf_q = mbb;
                    r.read_data = mask_q[0] ? (mb & PAL_MASK) : mb;
                end
                vaddr_q = vaddr_q + (ctrl_q[2] ? INC_ACROSS : INC_DOWN);
            end
            MODE_VBL_START:
            begin
                vbl_miss_q = 1'b1;
                status_q[7] = 1'b1;
            end
            MODE_VBL_MISS:
                vbl_miss_q = 1'b0;
            MODE_PRE_CLEAR:
                status_q = status_q & STATUS_PRE;
            default:
                ;
        endcase
        lvl = ctrl_q[7] & status_q[7];
        if (!r.mem_write)
            r.mem_address = vaddr_q;
        r.nmi_rise = lvl & ~nmi_q;
        nmi_q = lvl;
    endtask

    // Compare results first, then predict the transfer taken at this edge
    always @(posedge clk or negedge rst_n)
    begin
        bus_result_t got;
        bus_result_t want;
        bus_result_t pred;
        if (!rst_n)
        begin
            ctrl_q     = '0;
            mask_q     = '0;
            status_q   = '0;
            toggle_q   = 1'b0;
            vaddr_q    = '0;
            taddr_q    = '0;
            finex_q    = '0;
            rbuf_q     = '0;
            spr_addr_q = '0;
            vbl_miss_q = 1'b0;
            nmi_q      = 1'b0;
            for (int i = 0; i < 256; i++)
                spr_mem[i] = '0;
            expected_results.delete();
            pending <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.read_data      = m_tdata[7:0];
                got.mem_write      = m_tdata[8];
                got.mem_address    = m_tdata[23:9];
                got.mem_write_data = m_tdata[31:24];
                got.nmi_rise       = m_tdata[32];
                if (expected_results.size() == 0)
                begin
                    $error("result transfer with nothing expected: %h", m_tdata);
                    err_cnt++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.read_data !== want.read_data)
                    begin
                        $error("read_data: expected %h, got %h", want.read_data,
                               got.read_data);
                        err_cnt++;
                    end
                    if (got.mem_write !== want.mem_write)
                    begin
                        $error("mem_write: expected %b, got %b", want.mem_write,
                               got.mem_write);
                        err_cnt++;
                    end
                    if (got.mem_address !== want.mem_address)
                    begin
                        $error("mem_address: expected %h, got %h", want.mem_address,
                               got.mem_address);
                        err_cnt++;
                    end
                    if (got.mem_write_data !== want.mem_write_data)
                    begin
                        $error("mem_write_data: expected %h, got %h",
                               want.mem_write_data, got.mem_write_data);
                        err_cnt++;
                    end
                    if (got.nmi_rise !== want.nmi_rise)
                    begin
                        $error("nmi_rise: expected %b, got %b", want.nmi_rise,
                               got.nmi_rise);
                        err_cnt++;
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                apply_access(s_tuser, s_tdata[7:0], s_tdata[15:8], s_tdata[23:16],
                             s_tdata[24], pred);
                expected_results.push_back(pred);
            end
            pending <= expected_results.size();
        end
    end

endmodule

/* dv/tb.sv */
// Testbench top for the video register interface: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb;
    import vrif_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic [31:0] s_tdata = '0;
    logic [3:0]  s_tuser = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] m_tdata;
    logic        m_tvalid;
    logic        m_tready = 1'b0;

    int errors;
    int pending;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int sent = 0;
    logic rx_hold = 1'b0;
    logic hold_go = 1'b0;

    video_register_interface_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    vrif_checker chk (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .errors   (errors),
        .pending  (pending)
    );

    always #2 clk = ~clk;

    // Result side flow control
    always @(posedge clk)
    begin
        if (!rst_n || rx_hold)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Long receiver hold-off so the block backs up into its input
    initial
    begin
        wait (hold_go);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (400) @(posedge clk);
        rx_hold <= 1'b0;
    end

    // Run limit
    initial
    begin
        #2000000;
        $display("FAIL video_register_interface_core");
        $finish;
    end

    function automatic logic [7:0] rnd8();
        return 8'($urandom_range(255));
    endfunction

    function automatic logic rare_ignore();
        return ($urandom_range(9) == 0);
    endfunction

    // Offer one access and hold it until the transfer happens
    task automatic send(input logic [3:0] md, input logic [7:0] v, input logic [7:0] mb,
                        input logic [7:0] mbb, input logic ign);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= md;
        s_tdata  <= {7'd0, ign, mbb, mb, v};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sent++;
    endtask

    task automatic send_rnd(input logic [3:0] md, input logic [7:0] v, input logic ign);
        send(md, v, rnd8(), rnd8(), ign);
    endtask

    // Stop offering until every predicted result has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // Mostly well-formed register sequences, some raw noise
    task automatic run_random(input int target);
        int pick;
        int n;
        logic [7:0] base;
        target = sent + target;
        while (sent < target)
        begin
            pick = $urandom_range(99);
            if (pick < 30)
            begin
                // address setup then a burst of data accesses
                send_rnd(MODE_STATUS_RD, rnd8(), 1'b0);
                send_rnd(MODE_ADDR_WR, ($urandom_range(3) == 0) ? 8'h3f : rnd8(),
                         rare_ignore());
                send_rnd(MODE_ADDR_WR, rnd8(), rare_ignore());
                n = $urandom_range(1, 6);
                repeat (n)
                    send_rnd($urandom_range(1) ? MODE_DATA_RD : MODE_DATA_WR, rnd8(),
                             1'($urandom_range(1)));
            end
            else if (pick < 45)
                send_rnd($urandom_range(1) ? MODE_CTRL_WR : MODE_MASK_WR, rnd8(),
                         rare_ignore());
            else if (pick < 57)
            begin
                send_rnd(MODE_STATUS_RD, rnd8(), 1'b0);
                send_rnd(MODE_SCROLL_WR, rnd8(), rare_ignore());
                send_rnd(MODE_SCROLL_WR, rnd8(), rare_ignore());
            end
            else if (pick < 72)
            begin
                // sprite block write then read back
                base = rnd8();
                n = $urandom_range(1, 6);
                send_rnd(MODE_SPR_ADDR, base, 1'($urandom_range(1)));
                repeat (n)
                    send_rnd(MODE_SPR_WR, rnd8(), 1'($urandom_range(1)));
                send_rnd(MODE_SPR_ADDR, base, 1'($urandom_range(1)));
                send_rnd(MODE_SPR_RD, rnd8(), 1'($urandom_range(1)));
                send_rnd(MODE_SPR_ADDR, base + 8'($urandom_range(n)), 1'b0);
                send_rnd(MODE_SPR_RD, rnd8(), 1'b0);
            end
            else if (pick < 85)
            begin
                // one frame: vblank, optional nmi enable, status polls
                send_rnd(MODE_VBL_START, rnd8(), 1'($urandom_range(1)));
                if ($urandom_range(1))
                    send_rnd(MODE_CTRL_WR, rnd8(), rare_ignore());
                if ($urandom_range(1))
                    send_rnd(MODE_STATUS_RD, rnd8(), 1'b0);
                send_rnd(MODE_VBL_MISS, rnd8(), 1'($urandom_range(1)));
                if ($urandom_range(1))
                    send_rnd(MODE_STATUS_RD, rnd8(), 1'b0);
                send_rnd(MODE_PRE_CLEAR, rnd8(), 1'($urandom_range(1)));
            end
            else
                send(4'($urandom_range(15)), rnd8(), rnd8(), rnd8(),
                     1'($urandom_range(1)));
        end
    endtask

    // Stimulus and verdict
    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset contents, vblank hiding, nmi edge, sprite wrap and
        // attribute masking, palette bypass, increment by 32, unused codes
        send(MODE_STATUS_RD, 8'h00, 8'h00, 8'h00, 1'b0);
        send(MODE_SPR_RD, 8'h00, 8'h00, 8'h00, 1'b0);
        send(MODE_CTRL_WR, 8'hff, 8'hff, 8'hff, 1'b1);
        send(MODE_VBL_START, 8'h00, 8'h00, 8'h00, 1'b0);
        send(MODE_STATUS_RD, 8'h00, 8'h00, 8'h00, 1'b0);
        send(MODE_VBL_START, 8'h00, 8'h00, 8'h00, 1'b0);
        send(MODE_VBL_MISS, 8'h00, 8'h00, 8'h00, 1'b0);
        send(MODE_CTRL_WR, 8'h80, 8'h00, 8'h00, 1'b0);
        send(MODE_STATUS_RD, 8'h00, 8'h00, 8'h00, 1'b0);
        send(MODE_PRE_CLEAR, 8'h00, 8'h00, 8'h00, 1'b0);
        send(MODE_SPR_ADDR, 8'hfe, 8'h00, 8'h00, 1'b0);
        send(MODE_SPR_WR, 8'hff, 8'h00, 8'h00, 1'b0);
        send(MODE_SPR_WR, 8'hff, 8'h00, 8'h00, 1'b0);
        send(MODE_SPR_ADDR, 8'hfe, 8'h00, 8'h00, 1'b0);
        send(MODE_SPR_RD, 8'h00, 8'h00, 8'h00, 1'b0);
        send(MODE_SCROLL_WR, 8'hff, 8'h00, 8'h00, 1'b0);
        send(MODE_SCROLL_WR, 8'hff, 8'h00, 8'h00, 1'b0);
        send(MODE_ADDR_WR, 8'h3f, 8'h00, 8'h00, 1'b0);
        send(MODE_ADDR_WR, 8'h00, 8'h00, 8'h00, 1'b0);
        send(MODE_DATA_RD, 8'h00, 8'hff, 8'haa, 1'b0);
        send(MODE_MASK_WR, 8'hff, 8'h00, 8'h00, 1'b0);
        send(MODE_DATA_RD, 8'h00, 8'hff, 8'h55, 1'b0);
        send(MODE_CTRL_WR, 8'h04, 8'h00, 8'h00, 1'b0);
        send(MODE_DATA_WR, 8'hff, 8'h00, 8'h00, 1'b0);
        send(MODE_DATA_RD, 8'h00, 8'h12, 8'h34, 1'b0);
        send(4'd13, 8'hff, 8'hff, 8'hff, 1'b1);
        send(4'd15, 8'h00, 8'h00, 8'h00, 1'b0);

        // Sender sparse gaps, receiver mostly stalled
        tx_idle_pct <= 28;
        rx_idle_pct <= 87;
        run_random(500);
        drain();

        // Sender mostly idle, receiver mostly ready
        tx_idle_pct <= 87;
        rx_idle_pct <= 28;
        run_random(500);

        // Full rate, with one long receiver hold-off
        tx_idle_pct <= 0;
        rx_idle_pct <= 0;
        hold_go <= 1'b1;
        run_random(500);

        drain();
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("PASS video_register_interface_core");
        else
            $display("FAIL video_register_interface_core");
        $finish;
    end

endmodule
